// ----- rtl/ipv4dq_pkg.sv -----
// Package for the IPv4 dotted-quad parser: item types, parser state and
// character constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipv4dq_pkg;

  localparam logic [7:0] DotChar   = 8'h2E;
  localparam logic [7:0] ZeroChar  = 8'h30;
  localparam logic [7:0] NineChar  = 8'h39;
  localparam logic [11:0] MaxOctet = 12'd255;
  localparam logic [1:0] MaxDigits = 2'd3;
  localparam logic [1:0] MaxDots   = 2'd3;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic        is_valid;
    logic [31:0] address;
  } out_item_t;

  typedef struct packed {
    logic [23:0] upper_octets;
    logic [7:0]  field_value;
    logic [1:0]  field_digits;
    logic [1:0]  field_number;
    logic        error_seen;
  } parse_state_t;

  localparam parse_state_t StateClear = '0;

endpackage

`default_nettype wire

// ----- rtl/ipv4dq_step.sv -----
// Combinational character step: next parser state and the result item for
// one character. Depends on ipv4dq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipv4dq_step (
  input  ipv4dq_pkg::parse_state_t state_i,
  input  ipv4dq_pkg::in_item_t     item_i,
  output ipv4dq_pkg::parse_state_t state_o,
  output ipv4dq_pkg::out_item_t    result_o
);
  import ipv4dq_pkg::*;

  logic         is_digit;
  logic         is_dot;
  logic [3:0]   digit;
  logic [11:0]  times_ten;
  logic [11:0]  new_value;
  parse_state_t upd;
  logic         ok;

  assign is_digit  = (item_i.char_byte >= ZeroChar) && (item_i.char_byte <= NineChar);
  assign is_dot    = (item_i.char_byte == DotChar);
  assign digit     = 4'(item_i.char_byte - ZeroChar);
  assign times_ten = {1'b0, state_i.field_value, 3'b000} + {3'b000, state_i.field_value, 1'b0};
  assign new_value = times_ten + {8'h00, digit};

  always_comb begin
    upd = state_i;
    if (!state_i.error_seen) begin
      if (is_digit) begin
        if (state_i.field_digits >= MaxDigits || new_value > MaxOctet) begin
          upd.error_seen = 1'b1;
        end else begin
          upd.field_value  = new_value[7:0];
          upd.field_digits = state_i.field_digits + 2'd1;
        end
      end else if (is_dot) begin
        if (state_i.field_digits == 2'd0 || state_i.field_number >= MaxDots) begin
          upd.error_seen = 1'b1;
        end else begin
          upd.upper_octets = {state_i.upper_octets[15:0], state_i.field_value};
          upd.field_number = state_i.field_number + 2'd1;
          upd.field_value  = '0;
          upd.field_digits = '0;
        end
      end else begin
        upd.error_seen = 1'b1;
      end
    end
  end

  assign ok = !upd.error_seen && (upd.field_number == MaxDots) && (upd.field_digits != 2'd0);

  assign result_o.is_valid = ok;
  assign result_o.address  = ok ? {upd.upper_octets, upd.field_value} : 32'd0;
  assign state_o           = item_i.last_char ? StateClear : upd;

endmodule

`default_nettype wire

// ----- rtl/ipv4dq_parser_unit.sv -----
// Top level of the IPv4 dotted-quad parser: input register, parser state,
// output register. Depends on ipv4dq_pkg and ipv4dq_step.
`timescale 1ns / 1ps
`default_nettype none
// A final character passes the input register; its result then loads the output register.
// Throughput: one character per cycle; a final character waits only while
// an earlier result sits stalled in the output register.
// Reset clears the input and output valid flags and the parser state.

module ipv4_dotted_quad_parser_unit (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  ipv4dq_pkg::in_item_t    in_item_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output ipv4dq_pkg::out_item_t   out_item_o
);
  import ipv4dq_pkg::*;

  logic         in_vld_q, in_vld_d;
  in_item_t     in_item_q;
  parse_state_t state_q, state_d;
  logic         out_vld_q, out_vld_d;
  out_item_t    out_item_q;
  parse_state_t step_state;
  out_item_t    step_result;
  logic         out_free;
  logic         advance;
  logic         in_take;
  logic         out_load;

  ipv4dq_step u_step (
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (step_state),
    .result_o (step_result)
  );

  assign out_free = !out_vld_q || !out_stall_i;
  assign advance  = in_vld_q && (!in_item_q.last_char || out_free);
  assign out_load = advance && in_item_q.last_char;
  assign in_stall_o = in_vld_q && !advance;
  assign in_take  = in_valid_i && !in_stall_o;

  assign in_vld_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_q);
  assign state_d   = advance ? step_state : state_q;
  assign out_vld_d = out_load ? 1'b1 : (out_stall_i ? out_vld_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= StateClear;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      state_q   <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
    if (out_load) begin
      out_item_q <= step_result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ----- rtl/ipv4dq_checker.sv -----
// Port-level checks for the IPv4 dotted-quad parser, bound to its top level.
// Depends on ipv4dq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipv4dq_checker (
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   in_valid_i,
  input wire                   in_stall_o,
  input ipv4dq_pkg::in_item_t  in_item_i,
  input wire                   out_valid_o,
  input wire                   out_stall_i,
  input ipv4dq_pkg::out_item_t out_item_o
);
  import ipv4dq_pkg::*;

  // stalled input item stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled input item changed or withdrawn");

  // held result item must stay up until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled result item changed");

  // an invalid string reports a zero address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.is_valid |-> out_item_o.address == 32'd0)
    else $error("invalid result with nonzero address");

  // input backs up only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

bind ipv4_dotted_quad_parser_unit ipv4dq_checker u_ipv4dq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

// ----- dv/ipv4_dotted_quad_parser_unit_test.sv -----
// Testbench for ipv4_dotted_quad_parser_unit: sends address strings one character per item,
// predicts each parse result in a scoreboard class and checks it. Needs ipv4dq_pkg and the RTL.
`timescale 1ns / 1ps

module ipv4_dotted_quad_parser_unit_test;
  import ipv4dq_pkg::*;

  typedef logic [7:0] char_q_t[$];

  class quad_scoreboard;
    logic [23:0] octets_done;
    logic [7:0]  cur_value;
    logic [1:0]  cur_digits;
    logic [1:0]  dots_seen;
    logic        broken;
    out_item_t   expected_q[$];
    int unsigned mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      octets_done = '0;
      cur_value   = '0;
      cur_digits  = '0;
      dots_seen   = '0;
      broken      = 1'b0;
    endfunction

    function void note_char(in_item_t it);
      logic [11:0] acc;
      out_item_t   res;
      logic        ok;
      if (!broken) begin
        if (it.char_byte >= ZeroChar && it.char_byte <= NineChar) begin
          acc = {4'd0, cur_value} * 12'd10 + {4'd0, it.char_byte - ZeroChar};
          if (cur_digits == MaxDigits || acc > MaxOctet) begin
            broken = 1'b1;
          end else begin
            cur_value  = acc[7:0];
            cur_digits = cur_digits + 2'd1;
          end
        end else if (it.char_byte == DotChar) begin
          if (cur_digits == 2'd0 || dots_seen == MaxDots) begin
            broken = 1'b1;
          end else begin
            octets_done = {octets_done[15:0], cur_value};
            dots_seen   = dots_seen + 2'd1;
            cur_value   = '0;
            cur_digits  = '0;
          end
        end else begin
          broken = 1'b1;
        end
      end
      if (it.last_char) begin
        ok = !broken && dots_seen == MaxDots && cur_digits != 2'd0;
        res.is_valid = ok;
        res.address  = ok ? {octets_done, cur_value} : 32'd0;
        expected_q.push_back(res);
        clear();
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result valid=%0b addr=%h", $realtime, got.is_valid,
                   got.address);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (got.is_valid !== want.is_valid || got.address !== want.address) begin
          if (mismatches < 10)
            $display("%0t: result mismatch: expected valid=%0b addr=%h, got valid=%0b addr=%h",
                     $realtime, want.is_valid, want.address, got.is_valid, got.address);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  int unsigned tx_idle_pct = 22;
  int unsigned rx_idle_pct = 48;
  logic        rx_hold = 1'b0;
  int unsigned chars_sent = 0;

  quad_scoreboard sb = new();

  ipv4_dotted_quad_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(negedge clk_i) begin
    if (rx_hold) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (rx_idle_pct > 0) && ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_char(in_item_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
    end
  end

  function automatic char_q_t text_chars(string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic string octet_text(int v);
    string t;
    t = $sformatf("%0d", v);
    if ($urandom_range(3) == 0) begin
      while (t.len() < 3) t = {"0", t};
    end
    return t;
  endfunction

  function automatic int pick_octet();
    case ($urandom_range(9))
      0: return 0;
      1: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // Mostly well-formed quads; the rest broken in one way or plain noise.
  function automatic char_q_t make_quad();
    string   f[4];
    string   s;
    char_q_t q;
    int      kind;
    int      k;
    int      pos;
    int      n;
    foreach (f[i]) f[i] = octet_text(pick_octet());
    kind = $urandom_range(99);
    k = $urandom_range(3);
    if (kind >= 65 && kind < 72) f[k] = $sformatf("%0d", $urandom_range(256, 999));
    else if (kind >= 72 && kind < 78) f[k] = $sformatf("%04d", $urandom_range(255));
    else if (kind >= 78 && kind < 82) f[k] = "";
    s = {f[0], ".", f[1], ".", f[2], ".", f[3]};
    q = text_chars(s);
    pos = $urandom_range(q.size() - 1);
    if (kind >= 82 && kind < 87) begin
      q[pos] = 8'($urandom_range(255));
    end else if (kind >= 87 && kind < 90) begin
      q.insert(pos, 8'($urandom_range(255)));
    end else if (kind >= 90 && kind < 92) begin
      q.delete(pos);
    end else if (kind >= 92 && kind < 95) begin
      q = q[0:pos];
    end else if (kind >= 95 && kind < 97) begin
      q.push_back(DotChar);
      q = {q, text_chars(octet_text(pick_octet()))};
    end else if (kind >= 97) begin
      q.delete();
      n = $urandom_range(1, 12);
      repeat (n) begin
        if ($urandom_range(1)) q.push_back(8'($urandom_range(255)));
        else q.push_back($urandom_range(3) == 0 ? DotChar : 8'(ZeroChar + $urandom_range(9)));
      end
    end
    return q;
  endfunction

  task automatic send_char(logic [7:0] c, logic last);
    @(negedge clk_i);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{char_byte: c, last_char: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_chars(char_q_t q);
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned n);
    int unsigned start;
    start = chars_sent;
    while (chars_sent - start < n) send_chars(make_quad());
  endtask

  task automatic hold_receiver(int unsigned cycles);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (cycles) @(posedge clk_i);
    rx_hold = 1'b0;
  endtask

  initial begin
    string   directed_text[$];
    char_q_t odd;
    int      fails;
    directed_text = '{"0.0.0.0", "255.255.255.255", "000.001.010.100", "199.99.9.249",
                      "256.1.1.1", "1.1.1.259", "0000.1.1.1", "1.2.3.0255", "1..2.3",
                      ".1.2.3", "1.2.3.", "1.2.3.4.", "1.2.3.4.5", "1.2.3", "7",
                      "a.b.c.d", "1.2.3.4 ", "192.168/1.1", "300.1.2.3", "10.0.0.1"};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_text[i]) send_chars(text_chars(directed_text[i]));
    odd = '{8'hFF};
    send_chars(odd);
    odd = text_chars("1.2.3.4");
    odd.insert(3, 8'h00);
    send_chars(odd);
    odd = '{8'h7F, 8'h80, DotChar, 8'h39};
    send_chars(odd);
    drain();

    run_random(400);
    drain();
    tx_idle_pct = 48;
    rx_idle_pct = 22;
    run_random(400);
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // receiver stuck while strings keep coming, so the input backs up
    fork
      hold_receiver(400);
      repeat (25) send_chars(make_quad());
    join
    drain();
    run_random(100);
    drain();
    repeat (10) @(posedge clk_i);

    fails = sb.mismatches + sb.pending();
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ipv4dq_pkg.sv
rtl/ipv4dq_step.sv
rtl/ipv4dq_parser_unit.sv
rtl/ipv4dq_checker.sv
dv/ipv4_dotted_quad_parser_unit_test.sv
